### hw/rtl/pipv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pipv_pkg;

	localparam int CoordW = 16;
	localparam int DiffW  = CoordW + 1;
	localparam int ProdW  = 2 * DiffW;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} op_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_e;

	typedef struct packed {
		logic [1:0]               operation;
		logic signed [CoordW-1:0] coord_x;
		logic signed [CoordW-1:0] coord_y;
	} item_t;

	typedef struct packed {
		logic inside_res;
		logic status;
	} result_t;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
	} vertex_t;

	// Status of the crossing evaluator as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic in_poly;
	} cross_stat_t;

endpackage

`default_nettype wire

### hw/rtl/pipv_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One vertex of the ring. It either takes a newly appended vertex or the
// vertex of its neighbour while the ring rotates.
module pipv_cell (
	input  wire logic             clk,
	input  wire logic             shift,
	input  wire logic             load,
	input  wire pipv_pkg::vertex_t load_v,
	input  wire pipv_pkg::vertex_t next_v,
	output pipv_pkg::vertex_t     v
);

	pipv_pkg::vertex_t v_q;

	always_ff @(posedge clk) begin
		if (load) begin
			v_q <= load_v;
		end else if (shift) begin
			v_q <= next_v;
		end
	end

	assign v = v_q;

endmodule

`default_nettype wire

### hw/rtl/pipv_cross.sv
`timescale 1ns / 1ps
`default_nettype none

// Crossing evaluator. Takes one segment per cycle (earlier vertex held in
// prev_q, later vertex at the head of the ring) and keeps the parity of
// crossings below the point and whether any crossing lies at or above it.
module pipv_cross (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 feed,
	input  wire logic                 seg_vld,
	input  wire pipv_pkg::vertex_t    head,
	input  wire pipv_pkg::vertex_t    point,
	output pipv_pkg::cross_stat_t     stat
);

	localparam int CoordW = pipv_pkg::CoordW;
	localparam int DiffW  = pipv_pkg::DiffW;
	localparam int ProdW  = pipv_pkg::ProdW;

	pipv_pkg::vertex_t prev_q;

	logic signed [CoordW-1:0] xe, ye, xl, yl, px, py;
	logic                     covers;

	logic                     vld_s1;
	logic signed [DiffW-1:0]  a_s1, b_s1, c_s1, d_s1;
	logic                     vld_s2;
	logic                     dneg_s2;
	logic signed [ProdW-1:0]  p_s2, q_s2;
	logic                     below;
	logic                     odd_q;
	logic                     above_q;

	assign xe = prev_q.x;
	assign ye = prev_q.y;
	assign xl = head.x;
	assign yl = head.y;
	assign px = point.x;
	assign py = point.y;

	// Half-open span: the later vertex's x is included, the earlier one's is not.
	// A vertical segment never covers.
	assign covers = ((px >= xl) && (px < xe)) || ((px > xe) && (px <= xl));

	always_ff @(posedge clk) begin
		if (feed) begin
			prev_q <= head;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= $signed({ye[CoordW-1], ye}) - $signed({yl[CoordW-1], yl});
		b_s1    <= $signed({px[CoordW-1], px}) - $signed({xl[CoordW-1], xl});
		c_s1    <= $signed({py[CoordW-1], py}) - $signed({yl[CoordW-1], yl});
		d_s1    <= $signed({xe[CoordW-1], xe}) - $signed({xl[CoordW-1], xl});
		p_s2    <= a_s1 * b_s1;
		q_s2    <= c_s1 * d_s1;
		dneg_s2 <= d_s1[DiffW-1];
	end

	// The crossing lies below the point when (ye-yl)(x-xl)/d < y-yl, with the
	// comparison flipped when d is negative.
	assign below = dneg_s2 ? (p_s2 > q_s2) : (p_s2 < q_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			odd_q   <= 1'b0;
			above_q <= 1'b0;
		end else begin
			vld_s1 <= seg_vld && covers;
			vld_s2 <= vld_s1;
			if (start) begin
				odd_q   <= 1'b0;
				above_q <= 1'b0;
			end else if (vld_s2) begin
				if (below) begin
					odd_q <= ~odd_q;
				end else begin
					above_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy    = vld_s1 | vld_s2;
	assign stat.in_poly = above_q & odd_q;

endmodule

`default_nettype wire

### hw/rtl/point_in_polygon_vertical_crossing.sv
`timescale 1ns / 1ps
`default_nettype none

// Point-in-polygon test by counting crossings along a vertical line.
// Input channel (item_valid / item_stall / item): each transaction carries an
// operation (clear the vertex table, append a vertex, query a point) and a
// signed coordinate pair. Output channel (result_valid / result_stall /
// result): exactly one transaction per input transaction, in order, with the
// query answer and a flag that marks an append dropped on a full table.
// The vertices live in a ring of MAX_VERTICES cells. A query rotates the whole
// ring once, one cell per cycle, so that every consecutive vertex pair passes
// a single crossing evaluator; the ring is back in its original order when the
// rotation ends. A query's answer waits until segments at the very end of a
// nearly full table have left the evaluator's two pipeline stages, then goes
// to a pending result register and on to the output register. A clear, an
// append and a query on an empty table skip the rotation and go straight to
// the pending register. The next transaction is accepted in the cycle after
// the result is loaded at the earliest; one transaction is in work at a time.
// The result sits in an output register: while the receiver stalls, a new
// input transaction is still accepted and worked on, and its result waits in
// the block until the output register is free.
// Reset empties the vertex table and the output register; the vertex cells
// themselves are not cleared, since only entries below the count are read.
module point_in_polygon_vertical_crossing #(
	parameter int MAX_VERTICES = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire pipv_pkg::item_t  item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output pipv_pkg::result_t     result
);

	localparam int StepW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CntW  = $clog2(MAX_VERTICES + 1);

	pipv_pkg::state_e      state_q, state_d;
	logic [StepW-1:0]      step_q;
	logic [CntW-1:0]       count_q;
	pipv_pkg::vertex_t     qry_q;
	pipv_pkg::result_t     res_q;
	pipv_pkg::result_t     result_q;
	logic                  result_valid_q;

	pipv_pkg::vertex_t     cell_v [MAX_VERTICES];
	pipv_pkg::vertex_t     item_v;
	pipv_pkg::cross_stat_t cstat;

	logic accept;
	logic is_clear, is_append, is_query;
	logic full, empty;
	logic run, step_last, seg_vld;
	logic out_free;
	logic res_from_item, res_from_cross, out_load;

	assign item_stall = (state_q != pipv_pkg::ST_IDLE);
	assign accept     = item_valid && !item_stall;

	assign is_clear  = (item.operation == pipv_pkg::OP_CLEAR);
	assign is_append = (item.operation == pipv_pkg::OP_APPEND);
	assign is_query  = (item.operation == pipv_pkg::OP_QUERY);

	assign full  = (count_q == CntW'(MAX_VERTICES));
	assign empty = (count_q == '0);

	assign item_v.x = item.coord_x;
	assign item_v.y = item.coord_y;

	assign run       = (state_q == pipv_pkg::ST_RUN);
	assign step_last = (step_q == StepW'(MAX_VERTICES - 1));
	// At step k the head of the ring shows vertex k, so segment k-1 is present
	// for every k from 1 up to the last stored vertex.
	assign seg_vld   = run && (step_q != '0) && (CntW'(step_q) < count_q);
	assign out_free  = !result_valid_q || !result_stall;

	// Vertex ring: cell i holds vertex i and takes cell i+1 when rotating.
	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
		pipv_cell u_cell (
			.clk    (clk),
			.shift  (run),
			.load   (accept && is_append && (count_q == CntW'(i))),
			.load_v (item_v),
			.next_v (cell_v[(i + 1) % MAX_VERTICES]),
			.v      (cell_v[i])
		);
	end

	pipv_cross u_cross (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && is_query),
		.feed    (run),
		.seg_vld (seg_vld),
		.head    (cell_v[0]),
		.point   (qry_q),
		.stat    (cstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pipv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		res_from_item  = 1'b0;
		res_from_cross = 1'b0;
		out_load       = 1'b0;
		unique case (state_q)
			pipv_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_query && !empty) begin
						state_d = pipv_pkg::ST_RUN;
					end else begin
						res_from_item = 1'b1;
						state_d       = pipv_pkg::ST_DONE;
					end
				end
			end
			pipv_pkg::ST_RUN: begin
				if (step_last) begin
					state_d = pipv_pkg::ST_DRAIN;
				end
			end
			pipv_pkg::ST_DRAIN: begin
				if (!cstat.busy) begin
					res_from_cross = 1'b1;
					state_d        = pipv_pkg::ST_DONE;
				end
			end
			pipv_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = pipv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pipv_pkg::ST_IDLE;
			end
		endcase
	end

	// Vertex count and rotation step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			step_q  <= '0;
		end else begin
			if (accept && is_clear) begin
				count_q <= '0;
			end else if (accept && is_append && !full) begin
				count_q <= count_q + CntW'(1);
			end
			if (accept) begin
				step_q <= '0;
			end else if (run) begin
				step_q <= step_q + StepW'(1);
			end
		end
	end

	// Query point and the pending result.
	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			qry_q <= item_v;
		end
		if (res_from_item) begin
			res_q.inside_res <= is_query && empty;
			res_q.status     <= is_append && full;
		end else if (res_from_cross) begin
			res_q.inside_res <= cstat.in_poly;
			res_q.status     <= 1'b0;
		end
		if (out_load) begin
			result_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

### hw/rtl/pipv_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pipv_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_stall,
	input wire pipv_pkg::item_t   item,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire pipv_pkg::result_t result
);

	// A stalled input transaction stays offered and unchanged.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled input transaction changed or was withdrawn");

	// A stalled result transaction stays offered and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or was withdrawn");

	// Only one transaction is worked on at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second transaction accepted while one is in work");

	// A dropped append never carries a query answer.
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.status && result.inside_res))
		else $error("result flags both inside and dropped append");

endmodule

bind point_in_polygon_vertical_crossing pipv_checker u_pipv_checker (.*);

`default_nettype wire

### test/pipv_checker.sv
`timescale 1ns / 1ps

module pipv_tb_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  pipv_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  pipv_pkg::result_t result,
	output int                failures,
	output int                pending
);

	logic signed [pipv_pkg::CoordW-1:0] corner_x [TABLE_DEPTH];
	logic signed [pipv_pkg::CoordW-1:0] corner_y [TABLE_DEPTH];
	int                                 corner_count;
	pipv_pkg::result_t                  expected_answers [$];
	int                                 result_index;

	initial begin
		failures = 0;
		pending  = 0;
	end

	// Crossing count along the vertical line through the point, compared exactly by
	// cross-multiplication; the products fit easily in 64 bits.
	function automatic logic point_is_inside(input longint px, input longint py);
		longint xe, ye, xl, yl, span, lhs, rhs;
		int     below, above;
		logic   lies_below;
		below = 0;
		above = 0;
		if (corner_count == 0)
			return 1'b1;
		for (int i = 0; i + 1 < corner_count; i++) begin
			xe = corner_x[i];
			ye = corner_y[i];
			xl = corner_x[i + 1];
			yl = corner_y[i + 1];
			if (xl == xe)
				continue;
			if (!((px >= xl && px < xe) || (px > xe && px <= xl)))
				continue;
			span       = xe - xl;
			lhs        = (ye - yl) * (px - xl);
			rhs        = (py - yl) * span;
			lies_below = (span > 0) ? (lhs < rhs) : (lhs > rhs);
			if (lies_below)
				below++;
			else
				above++;
		end
		return (above != 0) && below[0];
	endfunction

	function automatic pipv_pkg::result_t vertex_table_step(input pipv_pkg::item_t it);
		pipv_pkg::result_t answer;
		answer = '0;
		case (it.operation)
			pipv_pkg::OP_CLEAR: corner_count = 0;
			pipv_pkg::OP_APPEND: begin
				if (corner_count >= TABLE_DEPTH) begin
					answer.status = 1'b1;
				end else begin
					corner_x[corner_count] = it.coord_x;
					corner_y[corner_count] = it.coord_y;
					corner_count++;
				end
			end
			pipv_pkg::OP_QUERY:
				answer.inside_res = point_is_inside(it.coord_x, it.coord_y);
			default: ;
		endcase
		return answer;
	endfunction

	task automatic report_mismatch(input string what);
		$display("ERROR: %0t ns, result %0d: %s", $realtime, result_index, what);
		failures++;
	endtask

	// Results are handled before the item of the same edge, since a result can never
	// belong to a transaction accepted at that very edge.
	always @(posedge clk or negedge arst_n) begin
		pipv_pkg::result_t want;
		pipv_pkg::result_t fresh;
		if (!arst_n) begin
			corner_count = 0;
			result_index = 0;
			expected_answers.delete();
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_answers.size() == 0) begin
					report_mismatch("result with no transaction waiting for it");
				end else begin
					want = expected_answers.pop_front();
					if (result.inside_res !== want.inside_res)
						report_mismatch($sformatf("inside_res %b, expected %b",
							result.inside_res, want.inside_res));
					if (result.status !== want.status)
						report_mismatch($sformatf("status %b, expected %b",
							result.status, want.status));
				end
				result_index++;
			end
			if (item_valid && !item_stall) begin
				fresh            = vertex_table_step(item);
				expected_answers = {expected_answers, fresh};
			end
		end
		pending = expected_answers.size();
	end

endmodule

### test/tb_point_in_polygon_vertical_crossing.sv
`timescale 1ns / 1ps

// Top of the point-in-polygon bench. This module only produces stimulus, paces
// both channels and gives the verdict; a separate checker instance watches both
// channels, keeps its own copy of the vertex table and compares every result
// transaction against its prediction.
module tb_point_in_polygon_vertical_crossing;

	localparam int         TABLE_DEPTH = 64;
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         ITEM_TARGET = 450;
	// The tail covers one full query rotation of the ring with some margin.
	localparam int         TAIL_CYCLES = TABLE_DEPTH + 16;
	// In the slowest correct run every transaction meets a sender gap, a full
	// query rotation and a receiver stall; there are perhaps 550 transactions.
	localparam int         CYCLE_LIMIT = 600000;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	pipv_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	pipv_pkg::result_t result;
	int                failures;
	int                pending;
	int                counted_items = 0;
	int                cycle_count   = 0;
	// Remaining transactions in a stretch where a side does not idle at all.
	int                sender_calm   = 0;
	int                receiver_calm = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	point_in_polygon_vertical_crossing #(
		.MAX_VERTICES(TABLE_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	pipv_tb_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) crossing_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.failures    (failures),
		.pending     (pending)
	);

	// Number of idle cycles before the next transaction on one side. Now and
	// then a side enters a calm stretch in which it does not idle at all, so
	// that back-to-back transactions are exercised as well as gaps.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 19);
	endfunction

	// A reach of zero means the full signed 16-bit range; otherwise the value is
	// drawn from a small window around the origin, where crossings are frequent.
	function automatic int pick_coord(input int reach);
		if (reach == 0)
			return int'($urandom_range(0, 65535)) - 32768;
		return int'($urandom_range(0, 2 * reach)) - reach;
	endfunction

	// Presents one transaction at a falling edge and holds it until it is taken.
	// The task is always entered and left on a falling edge, and the valid line
	// is assigned at most once in any time step.
	task automatic send(input logic [1:0] op, input int x, input int y);
		pipv_pkg::item_t txn;
		int              gap;
		txn.operation = op;
		txn.coord_x   = x[pipv_pkg::CoordW-1:0];
		txn.coord_y   = y[pipv_pkg::CoordW-1:0];
		gap = draw_wait(sender_calm);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item       <= txn;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
		// The unused operation code leaves the block untouched, so it does not
		// count towards the amount of stimulus.
		if (op != OP_UNUSED)
			counted_items++;
	endtask

	// A well-formed sequence: clear the table, build a polygon and query it.
	// Most polygons are short and drawn in a small window; a few are long, and a
	// few overrun the table so that dropped appends are flagged. Query points are
	// often placed on or next to a stored vertex, which hits the span ends and
	// crossings that lie exactly on the query's y.
	task automatic polygon_sequence();
		int xs [$];
		int ys [$];
		int corners, queries, reach, pick, qx, qy;
		reach = ($urandom_range(0, 9) < 6) ? $urandom_range(2, 40) : 0;
		pick  = $urandom_range(0, 19);
		if (pick < 16)
			corners = $urandom_range(0, 10);
		else if (pick < 19)
			corners = $urandom_range(11, 40);
		else
			corners = $urandom_range(60, 70);
		send(pipv_pkg::OP_CLEAR, pick_coord(0), pick_coord(0));
		for (int i = 0; i < corners; i++) begin
			xs = {xs, pick_coord(reach)};
			ys = {ys, pick_coord(reach)};
			send(pipv_pkg::OP_APPEND, xs[i], ys[i]);
			// The odd query on a half-built polygon.
			if ($urandom_range(0, 7) == 0)
				send(pipv_pkg::OP_QUERY, pick_coord(reach), pick_coord(reach));
		end
		queries = $urandom_range(1, 6);
		for (int q = 0; q < queries; q++) begin
			qx = pick_coord(reach);
			qy = pick_coord(reach);
			if (corners > 0 && $urandom_range(0, 1) == 1) begin
				pick = $urandom_range(0, corners - 1);
				qx   = xs[pick] + int'($urandom_range(0, 2)) - 1;
				if ($urandom_range(0, 1) == 1)
					qy = ys[pick];
			end
			send(pipv_pkg::OP_QUERY, qx, qy);
		end
	endtask

	// Noise: any operation code, including the unused one, with coordinates over
	// the whole range and no regard for the table's current contents.
	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 4);
		repeat (n)
			send(2'($urandom_range(0, 3)), pick_coord(0), pick_coord(0));
	endtask

	// The receiver stalls for a drawn number of cycles once a result is offered,
	// then takes it. A drawn stall of zero accepts the result as soon as it shows.
	initial begin : receiver
		int hold;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = draw_wait(receiver_calm);
			if (hold > 0) begin
				result_stall <= 1'b1;
				do @(posedge clk); while (!result_valid);
				repeat (hold - 1) @(posedge clk);
				@(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. A query on the empty table reports inside.
		send(pipv_pkg::OP_QUERY, 5, -5);
		// The unused code must change nothing and answer with zeros.
		send(OP_UNUSED, 32767, -32768);
		// A single vertex has no segment, so the answer is outside even on it.
		send(pipv_pkg::OP_APPEND, 0, 0);
		send(pipv_pkg::OP_QUERY, 0, 0);
		send(pipv_pkg::OP_CLEAR, -1, 32767);

		// A square closed by appending its first vertex again: the bottom and top
		// edges are the only non-vertical segments, as the block adds no closing one.
		send(pipv_pkg::OP_APPEND, -10, -10);
		send(pipv_pkg::OP_APPEND, 10, -10);
		send(pipv_pkg::OP_APPEND, 10, 10);
		send(pipv_pkg::OP_APPEND, -10, 10);
		send(pipv_pkg::OP_APPEND, -10, -10);
		send(pipv_pkg::OP_QUERY, 0, 0);
		// Crossing exactly on the point's y counts as at or above.
		send(pipv_pkg::OP_QUERY, 0, -10);
		// The x of the later vertex of a segment is covered, that of the earlier
		// one is not.
		send(pipv_pkg::OP_QUERY, 10, 0);
		send(pipv_pkg::OP_QUERY, -10, 0);
		send(pipv_pkg::OP_QUERY, 0, 20);
		send(pipv_pkg::OP_QUERY, 0, -20);

		// Extremes of both coordinates, a long diagonal and a vertical segment.
		send(pipv_pkg::OP_CLEAR, 0, 0);
		send(pipv_pkg::OP_APPEND, -32768, -32768);
		send(pipv_pkg::OP_APPEND, 32767, 32767);
		send(pipv_pkg::OP_APPEND, 32767, -32768);
		send(pipv_pkg::OP_APPEND, -32768, 32767);
		send(pipv_pkg::OP_QUERY, 0, 0);
		send(pipv_pkg::OP_QUERY, -1, -1);
		send(pipv_pkg::OP_QUERY, 32767, -32768);
		send(pipv_pkg::OP_QUERY, -32768, 32767);

		// Random part: mostly well-formed polygons, with bursts of noise.
		while (counted_items < ITEM_TARGET) begin
			if ($urandom_range(0, 6) == 0)
				noise_burst();
			else
				polygon_sequence();
		end
		item_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
